### rtl/cmm_pkg.sv
// shared types, constants and saturating add for the conference mix-minus block
`timescale 1ns / 1ps
`default_nettype none

package cmm_pkg;

  localparam int MaxSpeakers = 16;
  localparam int IdW         = 4;
  localparam int SampleW     = 16;
  localparam int CntW        = $clog2(MaxSpeakers + 1);
  localparam int InDataW     = ((IdW + SampleW + 7) / 8) * 8;
  localparam int OutDataW    = ((IdW + SampleW + 7) / 8) * 8;

  localparam logic signed [SampleW:0]   SatHi     = 17'sd32767;
  localparam logic signed [SampleW:0]   SatLo     = -17'sd32767;
  localparam logic signed [SampleW-1:0] SatHiVal  = 16'sd32766;
  localparam logic signed [SampleW-1:0] SatLoVal  = -16'sd32766;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } cmm_state_e;

  // one arrival slot held by a cell
  typedef struct packed {
    logic                      occ;
    logic                      usable;
    logic [IdW-1:0]            id;
    logic signed [SampleW-1:0] sum;
  } cmm_slot_t;

  // control broadcast from the top to every cell
  typedef struct packed {
    logic                      load;
    logic                      drain;
    logic                      clear;
    logic                      arr_usable;
    logic [IdW-1:0]            arr_id;
    logic signed [SampleW-1:0] arr_sample;
  } cmm_ctrl_t;

  function automatic logic signed [SampleW-1:0] sat_add(
    input logic signed [SampleW-1:0] acc,
    input logic signed [SampleW-1:0] smp
  );
    logic signed [SampleW:0] v;
    v = {acc[SampleW-1], acc} + {smp[SampleW-1], smp};
    if (v > SatHi) begin
      return SatHiVal;
    end else if (v < SatLo) begin
      return SatLoVal;
    end
    return v[SampleW-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/cmm_cell.sv
// one arrival slot of the mix-minus chain: id, usable mark and its running mix
`timescale 1ns / 1ps
`default_nettype none

module cmm_cell
  import cmm_pkg::*;
(
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire cmm_ctrl_t           ctrl_i,
  input  wire cmm_slot_t           newer_i,  // updated slot of the newer neighbor
  input  wire cmm_slot_t           older_i,  // stored slot of the older neighbor
  input  wire logic signed [SampleW-1:0] sel_i,
  output logic signed [SampleW-1:0]      sel_o,
  output cmm_slot_t                slot_o,
  output cmm_slot_t                upd_o
);

  cmm_slot_t slot_q, slot_d;
  logic      same_id;
  logic      hit;
  logic      add;

  always_comb begin
    same_id = (slot_q.id == ctrl_i.arr_id);
    hit     = slot_q.occ & slot_q.usable & same_id;
    add     = ctrl_i.arr_usable & slot_q.occ & slot_q.usable & ~same_id;
    // newest matching slot wins the seed for a repeated identity
    sel_o   = hit ? slot_q.sum : sel_i;
    upd_o   = slot_q;
    if (add) begin
      upd_o.sum = sat_add(slot_q.sum, ctrl_i.arr_sample);
    end
  end

  always_comb begin
    priority if (ctrl_i.clear) begin
      slot_d = '0;
    end else if (ctrl_i.load) begin
      slot_d = newer_i;
    end else if (ctrl_i.drain) begin
      slot_d = older_i;
    end else begin
      slot_d = slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

### rtl/conference_mix_minus.sv
// top level of the conference mix-minus block: chain of slot cells and drain control
//
// usage
// - slave channel: one request per speaker of a sample instant, in arrival order;
//   tlast marks the last speaker and closes the instant
// - master channel: the listener mix first (if listeners are present and more
//   than one speaker arrived), then one mix per usable speaker, newest first;
//   tlast marks the final result of the instant
// - a single speaker passes its raw sample to the listeners as the only result
// - speakers beyond the chain length are dropped; a closing one still closes
// loading and draining
// - loading: all cells update their sums in parallel and the chain shifts the
//   new slot in at the head
// - after the closing request the chain drains: the listener mix, then each slot
//   from the head down to the oldest usable one, then a clear; a single speaker's
//   result comes together with the clear; the first result is registered from the drain state
// - no request is taken while the chain drains
// reset and stall
// - reset empties the chain and the output register
// - a stalled receiver holds the output register and stops the drain at its next result; unusable slots still shift out
`timescale 1ns / 1ps
`default_nettype none

module conference_mix_minus
  import cmm_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [InDataW-1:0]   s_axis_tdata,   // speaker_id, sample, zero pad
  input  wire                 s_axis_tlast,   // last_speaker
  input  wire [1:0]           s_axis_tuser,   // usable, listeners_present
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // target_id, mixed, zero pad
  output logic                m_axis_tlast,   // last
  output logic [0:0]          m_axis_tuser    // to_listeners
);

  // input fields
  logic [IdW-1:0]            in_id;
  logic signed [SampleW-1:0] in_sample;
  logic                      in_usable;
  logic                      in_lis;

  assign in_id     = s_axis_tdata[IdW-1:0];
  assign in_sample = s_axis_tdata[IdW+SampleW-1:IdW];
  assign in_usable = s_axis_tuser[0];
  assign in_lis    = s_axis_tuser[1];

  // control state
  cmm_state_e                state_q, state_d;
  logic [CntW-1:0]           cnt_q, cnt_d, cnt_new;
  logic signed [SampleW-1:0] total_q, total_d;   // mix of all usable speakers
  logic signed [SampleW-1:0] first_q, first_d;   // raw sample of the first arrival
  logic                      lis_q, lis_d;       // listener mix still owed
  logic                      single_q, single_d; // instant had one speaker

  // output register
  logic                      ovalid_q, ovalid_d;
  logic [IdW-1:0]            otarget_q, otarget_d;
  logic                      olis_q, olis_d;
  logic signed [SampleW-1:0] omix_q, omix_d;
  logic                      olast_q, olast_d;

  // chain wiring
  cmm_ctrl_t                 ctrl;
  cmm_slot_t                 slot [MaxSpeakers];
  cmm_slot_t                 upd  [MaxSpeakers];
  logic signed [SampleW-1:0] sel  [MaxSpeakers+1];
  cmm_slot_t                 head_new;
  logic [MaxSpeakers-1:0]    occ_vec;
  logic [MaxSpeakers-1:0]    use_vec;
  logic                      any_use;
  logic                      rest_use;

  logic accept;
  logic store;
  logic out_free;

  // the oldest end of the seed chain starts from the mix of all usable speakers
  assign sel[MaxSpeakers] = total_q;

  for (genvar i = 0; i < MaxSpeakers; i++) begin : g_cell
    cmm_slot_t newer;
    cmm_slot_t older;
    if (i == 0) begin : g_head
      assign newer = head_new;
    end else begin : g_body
      assign newer = upd[i-1];
    end
    if (i == MaxSpeakers - 1) begin : g_tail
      assign older = '0;
    end else begin : g_mid
      assign older = slot[i+1];
    end

    cmm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .newer_i (newer),
      .older_i (older),
      .sel_i   (sel[i+1]),
      .sel_o   (sel[i]),
      .slot_o  (slot[i]),
      .upd_o   (upd[i])
    );

    assign occ_vec[i] = slot[i].occ;
    assign use_vec[i] = slot[i].occ & slot[i].usable;
  end

  assign any_use  = |use_vec;
  assign rest_use = |use_vec[MaxSpeakers-1:1];

  // new slot entering at the head: seeded from the newest usable same-id slot or the full mix; zero if unusable
  always_comb begin
    head_new.occ    = 1'b1;
    head_new.usable = in_usable;
    head_new.id     = in_id;
    head_new.sum    = in_usable ? sel[0] : '0;
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign store         = accept & (cnt_q < CntW'(MaxSpeakers));
  assign cnt_new       = store ? CntW'(cnt_q + 1'b1) : cnt_q;
  assign out_free      = ~ovalid_q | m_axis_tready;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    total_d   = total_q;
    first_d   = first_q;
    lis_d     = lis_q;
    single_d  = single_q;
    ovalid_d  = ovalid_q & ~m_axis_tready;
    otarget_d = otarget_q;
    olis_d    = olis_q;
    omix_d    = omix_q;
    olast_d   = olast_q;

    ctrl.load       = 1'b0;
    ctrl.drain      = 1'b0;
    ctrl.clear      = 1'b0;
    ctrl.arr_usable = 1'b0;
    ctrl.arr_id     = in_id;
    ctrl.arr_sample = in_sample;

    unique case (state_q)
      ST_LOAD: begin
        if (store) begin
          ctrl.load       = 1'b1;
          ctrl.arr_usable = in_usable;
          cnt_d           = cnt_new;
          if (in_usable) begin
            total_d = sat_add(total_q, in_sample);
          end
          if (cnt_q == '0) begin
            first_d = in_sample;
          end
        end
        if (accept && s_axis_tlast) begin
          state_d  = ST_DRAIN;
          single_d = (cnt_new == CntW'(1));
          lis_d    = in_lis & (cnt_new > CntW'(1));
        end
      end
      ST_DRAIN: begin
        priority if (single_q) begin
          if (out_free) begin
            ovalid_d   = 1'b1;
            otarget_d  = '0;
            olis_d     = 1'b1;
            omix_d     = first_q;
            olast_d    = 1'b1;
            ctrl.clear = 1'b1;
            state_d    = ST_LOAD;
          end
        end else if (lis_q) begin
          if (out_free) begin
            ovalid_d  = 1'b1;
            otarget_d = '0;
            olis_d    = 1'b1;
            omix_d    = total_q;
            olast_d   = ~any_use;
            lis_d     = 1'b0;
          end
        end else if (any_use) begin
          // slots leave from the head, newest first; unusable ones just shift out
          if (use_vec[0]) begin
            if (out_free) begin
              ovalid_d   = 1'b1;
              otarget_d  = slot[0].id;
              olis_d     = 1'b0;
              omix_d     = slot[0].sum;
              olast_d    = ~rest_use;
              ctrl.drain = 1'b1;
            end
          end else begin
            ctrl.drain = 1'b1;
          end
        end else begin
          ctrl.clear = 1'b1;
          state_d    = ST_LOAD;
        end
        if (ctrl.clear) begin
          cnt_d    = '0;
          total_d  = '0;
          first_d  = '0;
          lis_d    = 1'b0;
          single_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      total_q  <= '0;
      first_q  <= '0;
      lis_q    <= 1'b0;
      single_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      total_q  <= total_d;
      first_q  <= first_d;
      lis_q    <= lis_d;
      single_q <= single_d;
      ovalid_q <= ovalid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    otarget_q <= otarget_d;
    olis_q    <= olis_d;
    omix_q    <= omix_d;
    olast_q   <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {{(OutDataW - IdW - SampleW){1'b0}}, omix_q, otarget_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = olis_q;

  // arrival count never exceeds the chain length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxSpeakers))
    else $error("arrival count beyond chain length");

  // while loading, the occupied cells match the arrival count
  a_occ_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOAD |-> $countones(occ_vec) == int'(cnt_q))
    else $error("cell occupancy out of step with arrival count");

  // a clear empties the chain and the counters
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.clear |=> occ_vec == '0 && cnt_q == '0 && state_q == ST_LOAD)
    else $error("chain not empty after clear");

  // the listener mix always carries target zero
  a_lis_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && olis_q |-> otarget_q == '0)
    else $error("listener mix with nonzero target");

endmodule

`default_nettype wire
